// ===== rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg: shared codes and types of the MSI snooping cache block
// Line states, bus request codes, multiplier operation codes and the result
// record passed from the snoop logic to the output stage.
// ----------------------------------------------------------------------------
package msc_pkg;

  // MSI line states
  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_M = 2'd2;

  // snoop bus requests
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_RD   = 2'd1;
  localparam logic [1:0] REQ_INV  = 2'd2;
  localparam logic [1:0] REQ_RFO  = 2'd3;

  // shared multiplier operations
  localparam logic [1:0] MOP_RECIP_LB = 2'd0;  // times reciprocal of line size
  localparam logic [1:0] MOP_LB       = 2'd1;  // times line size
  localparam logic [1:0] MOP_RECIP_NL = 2'd2;  // times reciprocal of line count
  localparam logic [1:0] MOP_NL       = 2'd3;  // times line count

  typedef struct packed {
    logic       hit;
    logic [1:0] bus_request;
    logic [1:0] remote_copies;
    logic       supplier_valid;
    logic [1:0] supplier_core;
    logic [1:0] remote_writebacks;
    logic [1:0] remote_invalidations;
    logic       victim_writeback;
    logic [1:0] new_state;
  } result_t;

endpackage

// ===== rtl/msc_mul.sv =====
// ----------------------------------------------------------------------------
// msc_mul: shared registered multiplier
// Multiplies a 16-bit operand by one of four elaboration-time constants; every
// multiply of the address split into line index and tag runs through this unit.
// ----------------------------------------------------------------------------
module msc_mul #(
  parameter int LINE_BYTES = 16,
  parameter int NUM_LINES  = 64
) (
  input  logic        clk,
  input  logic        en,
  input  logic [1:0]  op,
  input  logic [15:0] a,
  output logic [47:0] prod_r
);

  // floor((2^32 - 1) / D): quotient estimate is exact or one low for 16-bit values
  localparam logic [31:0] RECIP_LB = 32'(64'hFFFF_FFFF / LINE_BYTES);
  localparam logic [31:0] RECIP_NL = 32'(64'hFFFF_FFFF / NUM_LINES);

  logic [31:0] b_sel;
  logic [47:0] prod;

  always_comb begin
    unique case (op)
      msc_pkg::MOP_RECIP_LB: b_sel = RECIP_LB;
      msc_pkg::MOP_LB:       b_sel = 32'(LINE_BYTES);
      msc_pkg::MOP_RECIP_NL: b_sel = RECIP_NL;
      default:               b_sel = 32'(NUM_LINES);
    endcase
  end

  assign prod = {32'd0, a} * {16'd0, b_sel};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
    end
  end

endmodule

// ===== rtl/msc_bank.sv =====
// ----------------------------------------------------------------------------
// msc_bank: line state and tag memories of all cores
// One row per line index holds every core's state and tag. States are swept
// to Invalid after reset; tags hold whatever they hold until written.
// ----------------------------------------------------------------------------
module msc_bank #(
  parameter int NUM_CORES = 4,
  parameter int NUM_LINES = 64,
  parameter int IDX_W     = 6,
  parameter int TAG_W     = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rd_en,
  input  logic [IDX_W-1:0]                  rd_idx,
  output logic [NUM_CORES-1:0][1:0]         rd_state_r,
  output logic [NUM_CORES-1:0][TAG_W-1:0]   rd_tag_r,
  input  logic                              wr_en,
  input  logic [IDX_W-1:0]                  wr_idx,
  input  logic [NUM_CORES-1:0][1:0]         wr_state,
  input  logic [NUM_CORES-1:0]              wr_tag_mask,
  input  logic [TAG_W-1:0]                  wr_tag,
  output logic                              clearing
);

  logic [NUM_CORES-1:0][1:0]       st_mem_r  [NUM_LINES];
  logic [NUM_CORES-1:0][TAG_W-1:0] tag_mem_r [NUM_LINES];
  logic                            clr_busy_r;
  logic [IDX_W-1:0]                clr_idx_r;

  assign clearing = clr_busy_r;

  // clearing sweep: one row per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == IDX_W'(NUM_LINES - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      st_mem_r[clr_idx_r] <= '0;
    end else if (wr_en) begin
      st_mem_r[wr_idx] <= wr_state;
    end
    if (rd_en) begin
      rd_state_r <= st_mem_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        if (wr_tag_mask[c]) begin
          tag_mem_r[wr_idx][c] <= wr_tag;
        end
      end
    end
    if (rd_en) begin
      rd_tag_r <= tag_mem_r[rd_idx];
    end
  end

endmodule

// ===== rtl/msc_snoop.sv =====
// ----------------------------------------------------------------------------
// msc_snoop: MSI snoop and update logic for one line row
// Looks up the requester and every remote cache, picks the bus request and
// forms the next row of states and the reported events.
// ----------------------------------------------------------------------------
module msc_snoop #(
  parameter int NUM_CORES = 4,
  parameter int TAG_W     = 6
) (
  input  logic [NUM_CORES-1:0][1:0]       st_row,
  input  logic [NUM_CORES-1:0][TAG_W-1:0] tag_row,
  input  logic [1:0]                      core,
  input  logic                            write,
  input  logic [TAG_W-1:0]                tag,
  output msc_pkg::result_t                res,
  output logic [NUM_CORES-1:0][1:0]       st_row_nxt,
  output logic [NUM_CORES-1:0]            tag_mask
);

  function automatic logic [1:0] sat3(input logic [4:0] n);
    return (n > 5'd3) ? 2'd3 : n[1:0];
  endfunction

  logic [NUM_CORES-1:0] is_me;
  logic [NUM_CORES-1:0] match;
  logic [NUM_CORES-1:0] remote_hit;
  logic [NUM_CORES-1:0] remote_m;
  logic                 ignore;
  logic                 hit;
  logic [1:0]           my_st;
  logic [1:0]           req;
  logic [1:0]           sup_c;
  logic                 own_req;

  always_comb begin
    ignore = ({30'd0, core} >= 32'(NUM_CORES));
    my_st  = msc_pkg::ST_I;
    for (int c = 0; c < NUM_CORES; c++) begin
      is_me[c] = ({30'd0, core} == 32'(c));
      match[c] = (st_row[c] != msc_pkg::ST_I) && (tag_row[c] == tag);
      if (is_me[c]) begin
        my_st = st_row[c];
      end
    end
    hit = |(is_me & match);

    priority if (hit && !write) begin
      req = msc_pkg::REQ_NONE;
    end else if (hit) begin
      req = (my_st == msc_pkg::ST_S) ? msc_pkg::REQ_INV : msc_pkg::REQ_NONE;
    end else begin
      req = write ? msc_pkg::REQ_RFO : msc_pkg::REQ_RD;
    end
    own_req = (req == msc_pkg::REQ_INV) || (req == msc_pkg::REQ_RFO);

    sup_c = 2'd0;
    for (int c = 0; c < NUM_CORES; c++) begin
      remote_hit[c] = match[c] && !is_me[c] && (req != msc_pkg::REQ_NONE);
      remote_m[c]   = remote_hit[c] && (st_row[c] == msc_pkg::ST_M);
      st_row_nxt[c] = st_row[c];
      if (remote_hit[c]) begin
        if (req == msc_pkg::REQ_RD) begin
          if (remote_m[c]) begin
            st_row_nxt[c] = msc_pkg::ST_S;
          end
        end else begin
          st_row_nxt[c] = msc_pkg::ST_I;
        end
      end
      if (is_me[c]) begin
        if (!hit) begin
          st_row_nxt[c] = write ? msc_pkg::ST_M : msc_pkg::ST_S;
        end else if (write) begin
          st_row_nxt[c] = msc_pkg::ST_M;
        end
      end
      // highest-numbered supplier wins
      if (remote_m[c]) begin
        sup_c = 2'(c);
      end
    end

    res.hit                  = hit;
    res.bus_request          = req;
    res.remote_copies        = sat3(5'($countones(remote_hit)));
    res.supplier_valid       = (req == msc_pkg::REQ_RD || req == msc_pkg::REQ_RFO) &&
                               (|remote_m);
    res.supplier_core        = res.supplier_valid ? sup_c : 2'd0;
    res.remote_writebacks    = sat3(5'($countones(remote_m)));
    res.remote_invalidations = own_req ? sat3(5'($countones(remote_hit))) : 2'd0;
    res.victim_writeback     = !hit && (my_st == msc_pkg::ST_M);
    res.new_state            = write ? msc_pkg::ST_M : (hit ? my_st : msc_pkg::ST_S);
    tag_mask                 = hit ? '0 : is_me;

    // out-of-range core: drop the access, report all zero
    if (ignore) begin
      res        = '0;
      st_row_nxt = st_row;
      tag_mask   = '0;
    end
  end

endmodule

// ===== rtl/msi_snooping_cache_coherence.sv =====
// ----------------------------------------------------------------------------
// msi_snooping_cache_coherence: MSI snooping coherence over per-core caches
// A request passes the address split, the row read and the snoop with row write,
// then gives its result strobe. Busy is high from accept until then, so no new
// request is taken while the shared multiplier splits the address and the line row
// takes a read-modify-write. The receiver cannot stall the result strobe.
// Reset: synchronous; state memory is swept to Invalid while busy stays high.
// ----------------------------------------------------------------------------
module msi_snooping_cache_coherence #(
  parameter int NUM_CORES  = 4,
  parameter int NUM_LINES  = 64,
  parameter int LINE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_core,
  input  logic        in_action,
  input  logic [15:0] in_addr,
  // result side
  output logic        out_valid,
  output logic        out_hit,
  output logic [1:0]  out_bus_request,
  output logic [1:0]  out_remote_copies,
  output logic        out_supplier_valid,
  output logic [1:0]  out_supplier_core,
  output logic [1:0]  out_remote_writebacks,
  output logic [1:0]  out_remote_invalidations,
  output logic        out_victim_writeback,
  output logic [1:0]  out_new_state
);

  localparam int IDX_W   = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int MAX_TAG = 65535 / (LINE_BYTES * NUM_LINES);
  localparam int TAG_W   = (MAX_TAG > 0) ? $clog2(MAX_TAG + 1) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL_A   = 4'd1;  // addr * 1/LINE_BYTES
  localparam logic [3:0] S_MUL_B   = 4'd2;  // quotient * LINE_BYTES
  localparam logic [3:0] S_FIX_BLK = 4'd3;  // correct block number
  localparam logic [3:0] S_MUL_C   = 4'd4;  // block * 1/NUM_LINES
  localparam logic [3:0] S_MUL_D   = 4'd5;  // tag * NUM_LINES
  localparam logic [3:0] S_FIX_IDX = 4'd6;  // correct tag, form index
  localparam logic [3:0] S_READ    = 4'd7;  // read line row
  localparam logic [3:0] S_EXEC    = 4'd8;  // snoop, write row, report

  logic [3:0]        state_r;
  logic [1:0]        core_r;
  logic              write_r;
  logic [15:0]       addr_r;
  logic [15:0]       q_r;
  logic [15:0]       blk_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TAG_W-1:0]  tag_r;
  logic              out_valid_r;
  msc_pkg::result_t  res_r;

  logic              accept;
  logic              clearing;
  logic              mul_en;
  logic [1:0]        mul_op;
  logic [15:0]       mul_a;
  logic [47:0]       prod_r;
  logic [16:0]       blk_rem;
  logic [15:0]       blk_nxt;
  logic [16:0]       idx_rem;
  logic              idx_over;

  logic [NUM_CORES-1:0][1:0]       rd_state;
  logic [NUM_CORES-1:0][TAG_W-1:0] rd_tag;
  logic [NUM_CORES-1:0][1:0]       st_row_nxt;
  logic [NUM_CORES-1:0]            tag_mask;
  msc_pkg::result_t                res;

  // hold off requests in reset, during the clearing sweep and while a request is in flight
  assign busy   = !rst_n || clearing || (state_r != S_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // Shared multiplier: operand and constant chosen by the sequencer step
  // ---------------------------------------------------------------------
  always_comb begin
    mul_en = 1'b0;
    mul_op = msc_pkg::MOP_RECIP_LB;
    mul_a  = prod_r[47:32];
    unique case (state_r)
      S_MUL_A: begin
        mul_en = 1'b1;
        mul_op = msc_pkg::MOP_RECIP_LB;
        mul_a  = addr_r;
      end
      S_MUL_B: begin
        mul_en = 1'b1;
        mul_op = msc_pkg::MOP_LB;
      end
      S_MUL_C: begin
        mul_en = 1'b1;
        mul_op = msc_pkg::MOP_RECIP_NL;
        mul_a  = blk_r;
      end
      S_MUL_D: begin
        mul_en = 1'b1;
        mul_op = msc_pkg::MOP_NL;
      end
      default: begin
      end
    endcase
  end

  msc_mul #(
    .LINE_BYTES (LINE_BYTES),
    .NUM_LINES  (NUM_LINES)
  ) u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op     (mul_op),
    .a      (mul_a),
    .prod_r (prod_r)
  );

  // The reciprocal estimate is exact or one low: one compare fixes it.
  assign blk_rem  = {1'b0, addr_r} - prod_r[16:0];
  assign blk_nxt  = (blk_rem >= 17'(LINE_BYTES)) ? q_r + 16'd1 : q_r;
  assign idx_rem  = {1'b0, blk_r} - prod_r[16:0];
  assign idx_over = (idx_rem >= 17'(NUM_LINES));

  // ---------------------------------------------------------------------
  // Line row storage and snoop logic
  // ---------------------------------------------------------------------
  msc_bank #(
    .NUM_CORES (NUM_CORES),
    .NUM_LINES (NUM_LINES),
    .IDX_W     (IDX_W),
    .TAG_W     (TAG_W)
  ) u_bank (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (state_r == S_READ),
    .rd_idx      (idx_r),
    .rd_state_r  (rd_state),
    .rd_tag_r    (rd_tag),
    .wr_en       (state_r == S_EXEC),
    .wr_idx      (idx_r),
    .wr_state    (st_row_nxt),
    .wr_tag_mask (tag_mask),
    .wr_tag      (tag_r),
    .clearing    (clearing)
  );

  msc_snoop #(
    .NUM_CORES (NUM_CORES),
    .TAG_W     (TAG_W)
  ) u_snoop (
    .st_row     (rd_state),
    .tag_row    (rd_tag),
    .core       (core_r),
    .write      (write_r),
    .tag        (tag_r),
    .res        (res),
    .st_row_nxt (st_row_nxt),
    .tag_mask   (tag_mask)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MUL_A;
          end
        end
        S_MUL_A:   state_r <= S_MUL_B;
        S_MUL_B:   state_r <= S_FIX_BLK;
        S_FIX_BLK: state_r <= S_MUL_C;
        S_MUL_C:   state_r <= S_MUL_D;
        S_MUL_D:   state_r <= S_FIX_IDX;
        S_FIX_IDX: state_r <= S_READ;
        S_READ:    state_r <= S_EXEC;
        S_EXEC: begin
          // result strobe for exactly one cycle
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default:   state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      core_r  <= in_core;
      write_r <= in_action;
      addr_r  <= in_addr;
    end
    if (state_r == S_MUL_B || state_r == S_MUL_D) begin
      q_r <= prod_r[47:32];
    end
    if (state_r == S_FIX_BLK) begin
      blk_r <= blk_nxt;
    end
    if (state_r == S_FIX_IDX) begin
      if (idx_over) begin
        idx_r <= IDX_W'(idx_rem - 17'(NUM_LINES));
        tag_r <= TAG_W'(q_r + 16'd1);
      end else begin
        idx_r <= IDX_W'(idx_rem);
        tag_r <= TAG_W'(q_r);
      end
    end
    if (state_r == S_EXEC) begin
      res_r <= res;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_hit                  = res_r.hit;
  assign out_bus_request          = res_r.bus_request;
  assign out_remote_copies        = res_r.remote_copies;
  assign out_supplier_valid       = res_r.supplier_valid;
  assign out_supplier_core        = res_r.supplier_core;
  assign out_remote_writebacks    = res_r.remote_writebacks;
  assign out_remote_invalidations = res_r.remote_invalidations;
  assign out_victim_writeback     = res_r.victim_writeback;
  assign out_new_state            = res_r.new_state;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // next request passes the whole sequencer first: a strobe never repeats
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  // an accepted request must lock out the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after request accept");

  // no bus request: no remote traffic reported
  a_quiet_bus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.bus_request == msc_pkg::REQ_NONE) |->
      (res_r.remote_copies == 2'd0 && res_r.remote_writebacks == 2'd0 &&
       res_r.remote_invalidations == 2'd0))
    else $error("remote events without a bus request");

  // a supplier is always a written-back Modified copy on a data request
  a_supplier: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.supplier_valid) |->
      (res_r.remote_writebacks != 2'd0 &&
       (res_r.bus_request == msc_pkg::REQ_RD || res_r.bus_request == msc_pkg::REQ_RFO)))
    else $error("supplier reported without a remote writeback");

endmodule

// ===== tb/msi_snooping_cache_coherence_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msi_snooping_cache_coherence_tb: self-checking bench for the MSI cache block
// Drives core/read-write/address requests through the start/busy handshake.
// A scoreboard keeps its own copy of every core's line tags and MSI states,
// predicts the snoop report for each accepted request and checks every
// result strobe field by field, in order.
// ----------------------------------------------------------------------------
module msi_snooping_cache_coherence_tb;

  localparam int NUM_CORES  = 4;
  localparam int NUM_LINES  = 64;
  localparam int LINE_BYTES = 16;

  // access kinds on in_action
  localparam logic ACT_RD = 1'b0;
  localparam logic ACT_WR = 1'b1;

  // give up after this many cycles with neither a request nor a result
  localparam int STALL_LIMIT  = 2000;
  // settle time after the last result: longer than one request takes to pass
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS  = 350;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the per-core line arrays and queues predicted reports
  // --------------------------------------------------------------------------
  class coherence_scoreboard;
    logic [1:0]        line_st [NUM_CORES*NUM_LINES];
    int                line_tg [NUM_CORES*NUM_LINES];
    msc_pkg::result_t  report_q [$];
    int                errors;

    function new();
      for (int k = 0; k < NUM_CORES*NUM_LINES; k++) begin
        line_st[k] = msc_pkg::ST_I;
        line_tg[k] = 0;
      end
      errors = 0;
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    function logic [1:0] sat3(int n);
      return (n > 3) ? 2'd3 : n[1:0];
    endfunction

    // Predict the report of one accepted request and update the mirror.
    function void note_request(logic [1:0] core, logic act, logic [15:0] addr);
      msc_pkg::result_t r;
      int               blk, idx, tag;
      int               me, k;
      int               copies, wbs, invs;
      blk = int'(addr) / LINE_BYTES;
      idx = blk % NUM_LINES;
      tag = blk / NUM_LINES;
      me = int'(core) * NUM_LINES + idx;
      r = '0;
      copies = 0;
      wbs = 0;
      invs = 0;
      r.hit = (line_st[me] != msc_pkg::ST_I) && (line_tg[me] == tag);
      if (r.hit) begin
        r.bus_request = (act == ACT_WR && line_st[me] == msc_pkg::ST_S) ?
                        msc_pkg::REQ_INV : msc_pkg::REQ_NONE;
      end else begin
        r.bus_request = (act == ACT_WR) ? msc_pkg::REQ_RFO : msc_pkg::REQ_RD;
      end
      // snoop every other cache holding this line
      if (r.bus_request != msc_pkg::REQ_NONE) begin
        for (int c = 0; c < NUM_CORES; c++) begin
          k = c * NUM_LINES + idx;
          if (c != int'(core) && line_st[k] != msc_pkg::ST_I && line_tg[k] == tag) begin
            copies++;
            if (line_st[k] == msc_pkg::ST_M) begin
              wbs++;
              if (r.bus_request != msc_pkg::REQ_INV) begin
                r.supplier_valid = 1'b1;
                r.supplier_core  = c[1:0];
              end
            end
            if (r.bus_request == msc_pkg::REQ_RD) begin
              if (line_st[k] == msc_pkg::ST_M) line_st[k] = msc_pkg::ST_S;
            end else begin
              invs++;
              line_st[k] = msc_pkg::ST_I;
            end
          end
        end
      end
      // fill or upgrade the local line
      if (!r.hit) begin
        r.victim_writeback = (line_st[me] == msc_pkg::ST_M);
        line_tg[me] = tag;
        line_st[me] = (act == ACT_WR) ? msc_pkg::ST_M : msc_pkg::ST_S;
      end else if (act == ACT_WR) begin
        line_st[me] = msc_pkg::ST_M;
      end
      r.new_state            = line_st[me];
      r.remote_copies        = sat3(copies);
      r.remote_writebacks    = sat3(wbs);
      r.remote_invalidations = sat3(invs);
      report_q.push_back(r);
    endfunction

    task report(string what, int exp_v, int got_v);
      $display("ERROR at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
      errors++;
    endtask

    task compare(string what, int exp_v, int got_v);
      if (exp_v != got_v) report(what, exp_v, got_v);
    endtask

    // Check one result strobe against the oldest prediction.
    task check_result(msc_pkg::result_t got);
      msc_pkg::result_t e;
      if (report_q.size() == 0) begin
        report("unexpected result, queue depth", 0, 1);
      end else begin
        e = report_q.pop_front();
        compare("hit", int'(e.hit), int'(got.hit));
        compare("bus_request", int'(e.bus_request), int'(got.bus_request));
        compare("remote_copies", int'(e.remote_copies), int'(got.remote_copies));
        compare("supplier_valid", int'(e.supplier_valid), int'(got.supplier_valid));
        compare("supplier_core", int'(e.supplier_core), int'(got.supplier_core));
        compare("remote_writebacks", int'(e.remote_writebacks),
                int'(got.remote_writebacks));
        compare("remote_invalidations", int'(e.remote_invalidations),
                int'(got.remote_invalidations));
        compare("victim_writeback", int'(e.victim_writeback),
                int'(got.victim_writeback));
        compare("new_state", int'(e.new_state), int'(got.new_state));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_core = '0;
  logic        in_action = ACT_RD;
  logic [15:0] in_addr = '0;
  logic        busy;
  logic        out_valid;
  logic        out_hit;
  logic [1:0]  out_bus_request;
  logic [1:0]  out_remote_copies;
  logic        out_supplier_valid;
  logic [1:0]  out_supplier_core;
  logic [1:0]  out_remote_writebacks;
  logic [1:0]  out_remote_invalidations;
  logic        out_victim_writeback;
  logic [1:0]  out_new_state;

  coherence_scoreboard sb;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  msi_snooping_cache_coherence #(
    .NUM_CORES (NUM_CORES),
    .NUM_LINES (NUM_LINES),
    .LINE_BYTES(LINE_BYTES)
  ) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_core                 (in_core),
    .in_action               (in_action),
    .in_addr                 (in_addr),
    .out_valid               (out_valid),
    .out_hit                 (out_hit),
    .out_bus_request         (out_bus_request),
    .out_remote_copies       (out_remote_copies),
    .out_supplier_valid      (out_supplier_valid),
    .out_supplier_core       (out_supplier_core),
    .out_remote_writebacks   (out_remote_writebacks),
    .out_remote_invalidations(out_remote_invalidations),
    .out_victim_writeback    (out_victim_writeback),
    .out_new_state           (out_new_state)
  );

  // --------------------------------------------------------------------------
  // Monitor: values read here are the ones settled before the edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    // check the strobe first; it always belongs to an older request
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result({out_hit, out_bus_request, out_remote_copies,
                       out_supplier_valid, out_supplier_core,
                       out_remote_writebacks, out_remote_invalidations,
                       out_victim_writeback, out_new_state});
    end
    if (rst_n && start && busy === 1'b0) begin
      sb.note_request(in_core, in_action, in_addr);
    end
  end

  // Watchdog: count cycles with no request taken and no result seen.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("msi_snooping_cache_coherence_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Hold start low for a random number of cycles, then present the request
  // and wait for the edge that takes it.
  task automatic send_request(input logic [1:0] core, input logic act,
                              input logic [15:0] addr, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_core   <= core;
    in_action <= act;
    in_addr   <= addr;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start and hold until every predicted report has come back; step past
  // the current edge first so the monitor has logged the request taken at it.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly hit a few hot lines so sharing, upgrades and evictions happen
  // often; the rest of the time pick any address.
  function automatic logic [15:0] pick_addr();
    logic [5:0] tag;
    logic [5:0] idx;
    logic [3:0] offs;
    offs = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: tag = 6'd0;
      1: tag = 6'd1;
      2: tag = 6'd62;
      default: tag = 6'd63;
    endcase
    case ($urandom_range(0, 2))
      0: idx = 6'd0;
      1: idx = 6'd42;
      default: idx = 6'd63;
    endcase
    if ($urandom_range(0, 99) < 25) return 16'($urandom_range(0, 65535));
    return {tag, idx, offs};
  endfunction

  task automatic run_phase(input int count, input int idle_pct);
    for (int n = 0; n < count; n++) begin
      // now and then let the block run completely dry
      if ($urandom_range(0, 199) == 0) drain();
      send_request(2'($urandom_range(0, NUM_CORES - 1)), 1'($urandom_range(0, 1)),
                   pick_addr(), idle_pct);
    end
  endtask

  // Directed walk: sharing by all four cores, upgrade with three
  // invalidations, write hit on Modified, read snoop of a Modified copy,
  // read for ownership with and without a supplier, dirty victim eviction,
  // and both address extremes.
  logic [18:0] directed [16] = '{
    {2'd0, ACT_RD, 16'h0000},  // cold read miss
    {2'd0, ACT_RD, 16'h0000},  // read hit
    {2'd1, ACT_RD, 16'h0000},  // second sharer
    {2'd2, ACT_RD, 16'h0004},  // third sharer, same line
    {2'd3, ACT_RD, 16'h000F},  // fourth sharer
    {2'd0, ACT_WR, 16'h0008},  // upgrade from Shared
    {2'd0, ACT_WR, 16'h0000},  // write hit on Modified
    {2'd1, ACT_RD, 16'h0000},  // read snoop of a Modified copy
    {2'd2, ACT_WR, 16'h0000},  // read for ownership, two sharers
    {2'd3, ACT_WR, 16'h0000},  // read for ownership from a Modified owner
    {2'd3, ACT_RD, 16'h0400},  // same index, new tag: dirty victim
    {2'd3, ACT_WR, 16'hFFFF},  // top address, write miss
    {2'd0, ACT_RD, 16'hFFFF},  // supplied by core 3
    {2'd1, ACT_WR, 16'hFFF0},  // invalidate two sharers
    {2'd1, ACT_RD, 16'hFFFF},  // read hit on Modified
    {2'd2, ACT_WR, 16'h8000}   // cold write miss
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_request(directed[i][18:17], directed[i][16], directed[i][15:0], 0);
    end
    drain();

    // sender idles about a third of the time, then mostly, then never
    run_phase(PHASE_ITEMS, 33);
    drain();
    run_phase(PHASE_ITEMS, 70);
    drain();
    run_phase(PHASE_ITEMS, 0);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("leftover predictions", 0, sb.pending());

    if (sb.errors == 0) begin
      $display("msi_snooping_cache_coherence_tb: done, clean");
    end else begin
      $display("msi_snooping_cache_coherence_tb: done, errors");
    end
    $finish;
  end

endmodule
